>>> rtl/oewc_pkg.sv
// ----------------------------------------------------------------------------
// oewc_pkg
// Shared widths, register indexes, constants and types for the orientation
// Euler window check.
// ----------------------------------------------------------------------------
package oewc_pkg;

   localparam int CORDIC_STEPS_DEF = 14;
   localparam int DW         = 34;   // D entry, exact sum of three Q2.14 products
   localparam int CW         = 36;   // CORDIC x/y datapath
   localparam int AW         = 20;   // CORDIC angle, radians at 2^-16
   localparam int FIFO_DEPTH = 4;
   localparam int IN_W       = 144;
   localparam int OUT_W      = 48;
   localparam int CFG_W      = 48;
   localparam int CFG_IDX_W  = 3;
   localparam int MARGIN_W   = 14;
   localparam int QW         = 18;   // Q5.13 angle before packing to Q3.13

   typedef enum logic [CFG_IDX_W-1:0] {
      REG_TARGET_ROW0  = 3'd0,
      REG_TARGET_ROW1  = 3'd1,
      REG_TARGET_ROW2  = 3'd2,
      REG_MIN_ANGLES   = 3'd3,
      REG_MAX_ANGLES   = 3'd4,
      REG_ANGLE_MARGIN = 3'd5
   } cfg_reg_type;

   localparam logic signed [AW-1:0] HALF_PI_Q16  = 20'sd102944;
   localparam logic [29:0]          INV_GAIN_Q30 = 30'd652032875;
   localparam logic signed [QW-1:0] PI_Q13       = 18'sd25736;
   localparam logic signed [QW-1:0] HALF_PI_Q13  = 18'sd12868;

   typedef struct packed {
      logic signed [DW-1:0] d00;
      logic signed [DW-1:0] d10;
      logic signed [DW-1:0] d20;
      logic signed [DW-1:0] d21;
      logic signed [DW-1:0] d22;
   } dmat_type;

   typedef struct packed {
      logic [CFG_W-1:0]    min_angles;
      logic [CFG_W-1:0]    max_angles;
      logic [MARGIN_W-1:0] margin;
   } window_type;

   // atan(2^-i) at 2^-16, rounded to nearest
   function automatic logic signed [AW-1:0] atan_q16(input int i);
      case (i)
         0:  return 20'sd51472;
         1:  return 20'sd30386;
         2:  return 20'sd16055;
         3:  return 20'sd8150;
         4:  return 20'sd4091;
         5:  return 20'sd2047;
         6:  return 20'sd1024;
         7:  return 20'sd512;
         8:  return 20'sd256;
         9:  return 20'sd128;
         10: return 20'sd64;
         11: return 20'sd32;
         12: return 20'sd16;
         13: return 20'sd8;
         14: return 20'sd4;
         15: return 20'sd2;
         16: return 20'sd1;
         default: return '0;
      endcase
   endfunction

endpackage

>>> rtl/oewc_front.sv
// ----------------------------------------------------------------------------
// oewc_front
// Accepts rotation matrices and forms the five needed entries of R * T^T.
// ----------------------------------------------------------------------------
module oewc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [oewc_pkg::IN_W-1:0]     req_tdata,
   input  logic [oewc_pkg::CFG_W-1:0]    target_row0,
   input  logic [oewc_pkg::CFG_W-1:0]    target_row1,
   input  logic [oewc_pkg::CFG_W-1:0]    target_row2,
   output logic                          push_o,
   output oewc_pkg::dmat_type            data_o,
   input  logic                          full_i
);
   import oewc_pkg::*;

   logic en;
   logic v1_ff, v2_ff;
   logic signed [15:0] m [0:2][0:2];
   logic signed [15:0] tg [0:2][0:2];
   logic signed [31:0] p_in [0:4][0:2];
   logic signed [31:0] p_ff [0:4][0:2];
   logic signed [DW-1:0] s_in [0:4];
   dmat_type d_ff;

   assign en         = !(v2_ff && full_i);
   assign req_tready = en;
   assign push_o     = v2_ff && !full_i;
   assign data_o     = d_ff;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            m[r][c] = req_tdata[16*(3*r+c) +: 16];
         end
      end
      for (int c = 0; c < 3; c++) begin
         tg[0][c] = target_row0[16*c +: 16];
         tg[1][c] = target_row1[16*c +: 16];
         tg[2][c] = target_row2[16*c +: 16];
      end
      for (int k = 0; k < 3; k++) begin
         p_in[0][k] = m[0][k] * tg[0][k];
         p_in[1][k] = m[1][k] * tg[0][k];
         p_in[2][k] = m[2][k] * tg[0][k];
         p_in[3][k] = m[2][k] * tg[1][k];
         p_in[4][k] = m[2][k] * tg[2][k];
      end
      for (int j = 0; j < 5; j++) begin
         s_in[j] = {{(DW-32){p_ff[j][0][31]}}, p_ff[j][0]}
                 + {{(DW-32){p_ff[j][1][31]}}, p_ff[j][1]}
                 + {{(DW-32){p_ff[j][2][31]}}, p_ff[j][2]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff      <= p_in;
         d_ff.d00  <= s_in[0];
         d_ff.d10  <= s_in[1];
         d_ff.d20  <= s_in[2];
         d_ff.d21  <= s_in[3];
         d_ff.d22  <= s_in[4];
      end
   end

endmodule

>>> rtl/oewc_fifo.sv
// ----------------------------------------------------------------------------
// oewc_fifo
// Short queue between front and back, with a registered head.
// ----------------------------------------------------------------------------
module oewc_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_i,
   input  oewc_pkg::dmat_type  data_i,
   output logic                full_o,
   input  logic                pop_i,
   output logic                valid_o,
   output oewc_pkg::dmat_type  data_o
);
   import oewc_pkg::*;

   localparam int PW = $clog2(FIFO_DEPTH);

   dmat_type mem [0:FIFO_DEPTH-1];
   logic [PW-1:0] wr_ff, rd_ff;
   logic [PW:0]   cnt_ff;
   logic          hv_ff;
   dmat_type      head_ff;
   logic          load;

   assign full_o  = (cnt_ff == (PW+1)'(FIFO_DEPTH));
   assign valid_o = hv_ff;
   assign data_o  = head_ff;
   // refill the head when it is empty or leaving
   assign load    = (!hv_ff || pop_i) && (cnt_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
         hv_ff  <= 1'b0;
      end else begin
         if (push_i) wr_ff <= wr_ff + 1'b1;
         if (load)   rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (PW+1)'(push_i) - (PW+1)'(load);
         if (load)       hv_ff <= 1'b1;
         else if (pop_i) hv_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push_i) mem[wr_ff] <= data_i;
      if (load)   head_ff    <= mem[rd_ff];
   end

endmodule

>>> rtl/oewc_cordic.sv
// ----------------------------------------------------------------------------
// oewc_cordic
// Pipelined vectoring CORDIC: one quadrant stage, then one stage per step.
// ----------------------------------------------------------------------------
module oewc_cordic #(
   parameter int STEPS = oewc_pkg::CORDIC_STEPS_DEF
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [oewc_pkg::CW-1:0] x_i,
   input  logic signed [oewc_pkg::CW-1:0] y_i,
   output logic signed [oewc_pkg::AW-1:0] z_o,
   output logic signed [oewc_pkg::CW-1:0] mag_o
);
   import oewc_pkg::*;

   logic signed [CW-1:0] x_ff [0:STEPS];
   logic signed [CW-1:0] y_ff [0:STEPS];
   logic signed [AW-1:0] z_ff [0:STEPS];
   logic                 zr_ff [0:STEPS];

   logic signed [CW-1:0] px, py;
   logic signed [AW-1:0] pz;

   // fold the left half plane onto the right by a quarter turn
   always_comb begin
      px = x_i;
      py = y_i;
      pz = '0;
      if (x_i < 0) begin
         if (y_i >= 0) begin
            px = y_i;
            py = -x_i;
            pz = HALF_PI_Q16;
         end else begin
            px = -y_i;
            py = x_i;
            pz = -HALF_PI_Q16;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]  <= px;
         y_ff[0]  <= py;
         z_ff[0]  <= pz;
         zr_ff[0] <= (x_i == 0) && (y_i == 0);
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      localparam logic signed [AW-1:0] ATAN_I = atan_q16(i);
      always_ff @(posedge clock) begin
         if (en) begin
            if (y_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + ATAN_I;
            end else begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - ATAN_I;
            end
            zr_ff[i+1] <= zr_ff[i];
         end
      end
   end

   assign z_o   = zr_ff[STEPS] ? '0 : z_ff[STEPS];
   assign mag_o = zr_ff[STEPS] ? '0 : x_ff[STEPS];

endmodule

>>> rtl/oewc_back.sv
// ----------------------------------------------------------------------------
// oewc_back
// Euler angles from D, gain correction, Q3.13 conversion and window test.
// ----------------------------------------------------------------------------
module oewc_back #(
   parameter int STEPS = oewc_pkg::CORDIC_STEPS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            valid_i,
   input  oewc_pkg::dmat_type              data_i,
   output logic                            pop_o,
   input  oewc_pkg::window_type            win_i,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [oewc_pkg::OUT_W-1:0]      rsp_tdata
);
   import oewc_pkg::*;

   localparam int HW = CW - 19;   // upper slice of the magnitude

   logic en;
   logic signed [AW-1:0] zx, zz, zy;
   logic signed [CW-1:0] magx;

   logic                 va_ff  [0:STEPS];
   logic signed [DW-1:0] d20_ff [0:STEPS];

   logic                 vm1_ff, vm2_ff;
   logic [47:0]          lo_ff;
   logic [HW+29:0]       hi_ff;
   logic signed [AW-1:0] ax1_ff, az1_ff, ax2_ff, az2_ff;
   logic signed [DW-1:0] d20m_ff;
   logic signed [CW-1:0] mag2_ff, ny_ff;
   logic [CW+29:0]       sum;

   logic                 vb_ff  [0:STEPS];
   logic signed [AW-1:0] axb_ff [0:STEPS];
   logic signed [AW-1:0] azb_ff [0:STEPS];

   logic                 vo_ff, inside_ff;
   logic signed [15:0]   aox_ff, aoz_ff;
   logic signed [14:0]   aoy_ff;
   logic signed [QW-1:0] qx, qy, qz;
   logic                 inside_in;

   function automatic logic signed [QW-1:0] to_q13(input logic signed [AW-1:0] a,
                                                   input logic signed [QW-1:0] lim);
      logic signed [AW:0] s;
      s = {a[AW-1], a} + (AW+1)'(4);
      s = s >>> 3;
      if (s > lim)       return lim;
      else if (s < -lim) return -lim;
      else               return s[QW-1:0];
   endfunction

   function automatic logic in_win(input logic signed [QW-1:0] a,
                                   input logic signed [15:0] mn,
                                   input logic signed [15:0] mx,
                                   input logic [MARGIN_W-1:0] eps);
      logic signed [19:0] up, dn;
      up = {{2{a[QW-1]}}, a} + {6'b0, eps};
      dn = {{2{a[QW-1]}}, a} - {6'b0, eps};
      return !(up < $signed({{4{mn[15]}}, mn})) && !(dn > $signed({{4{mx[15]}}, mx}));
   endfunction

   // the whole back pipe holds while the result waits
   assign en    = !vo_ff || rsp_tready;
   assign pop_o = en && valid_i;

   oewc_cordic #(.STEPS(STEPS)) u_cordic_x (
      .clock (clock),
      .en    (en),
      .x_i   ({{(CW-DW){data_i.d22[DW-1]}}, data_i.d22}),
      .y_i   ({{(CW-DW){data_i.d21[DW-1]}}, data_i.d21}),
      .z_o   (zx),
      .mag_o (magx)
   );

   oewc_cordic #(.STEPS(STEPS)) u_cordic_z (
      .clock (clock),
      .en    (en),
      .x_i   ({{(CW-DW){data_i.d00[DW-1]}}, data_i.d00}),
      .y_i   ({{(CW-DW){data_i.d10[DW-1]}}, data_i.d10}),
      .z_o   (zz),
      .mag_o ()
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= STEPS; k++) va_ff[k] <= 1'b0;
      end else if (en) begin
         va_ff[0] <= valid_i;
         for (int k = 1; k <= STEPS; k++) va_ff[k] <= va_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d20_ff[0] <= data_i.d20;
         for (int k = 1; k <= STEPS; k++) d20_ff[k] <= d20_ff[k-1];
      end
   end

   // magnitude times 1/K, split in two partial products
   assign sum = {hi_ff, 18'b0} + {{(CW-18){1'b0}}, lo_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         vm1_ff <= 1'b0;
         vm2_ff <= 1'b0;
      end else if (en) begin
         vm1_ff <= va_ff[STEPS];
         vm2_ff <= vm1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lo_ff   <= magx[17:0] * INV_GAIN_Q30;
         hi_ff   <= magx[CW-2:18] * INV_GAIN_Q30;
         ax1_ff  <= zx;
         az1_ff  <= zz;
         d20m_ff <= d20_ff[STEPS];
         mag2_ff <= $signed(sum[CW+29:30]);
         ny_ff   <= -{{(CW-DW){d20m_ff[DW-1]}}, d20m_ff};
         ax2_ff  <= ax1_ff;
         az2_ff  <= az1_ff;
      end
   end

   oewc_cordic #(.STEPS(STEPS)) u_cordic_y (
      .clock (clock),
      .en    (en),
      .x_i   (mag2_ff),
      .y_i   (ny_ff),
      .z_o   (zy),
      .mag_o ()
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= STEPS; k++) vb_ff[k] <= 1'b0;
      end else if (en) begin
         vb_ff[0] <= vm2_ff;
         for (int k = 1; k <= STEPS; k++) vb_ff[k] <= vb_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         axb_ff[0] <= ax2_ff;
         azb_ff[0] <= az2_ff;
         for (int k = 1; k <= STEPS; k++) begin
            axb_ff[k] <= axb_ff[k-1];
            azb_ff[k] <= azb_ff[k-1];
         end
      end
   end

   always_comb begin
      qx = to_q13(axb_ff[STEPS], PI_Q13);
      qy = to_q13(zy, HALF_PI_Q13);
      qz = to_q13(azb_ff[STEPS], PI_Q13);
      inside_in = in_win(qx, win_i.min_angles[15:0], win_i.max_angles[15:0], win_i.margin)
               && in_win(qy, win_i.min_angles[31:16], win_i.max_angles[31:16], win_i.margin)
               && in_win(qz, win_i.min_angles[47:32], win_i.max_angles[47:32], win_i.margin);
   end

   always_ff @(posedge clock) begin
      if (reset) vo_ff <= 1'b0;
      else if (en) vo_ff <= vb_ff[STEPS];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         inside_ff <= inside_in;
         aox_ff    <= qx[15:0];
         aoy_ff    <= qy[14:0];
         aoz_ff    <= qz[15:0];
      end
   end

   assign rsp_tvalid = vo_ff;
   assign rsp_tdata  = {aoz_ff, aoy_ff, aox_ff, inside_ff};

endmodule

>>> rtl/orientation_euler_window_check_unit.sv
// ----------------------------------------------------------------------------
// orientation_euler_window_check_unit
// Path: two chained CORDIC pipelines (x angle, then y angle).
// Throughput: one request per cycle while results are taken; a 4-entry
//   queue decouples front and back.
// Reset: synchronous, clears all valid state; target resets to identity,
//   bounds and margin to zero.
// ----------------------------------------------------------------------------
module orientation_euler_window_check_unit #(
   parameter int CORDIC_STEPS = oewc_pkg::CORDIC_STEPS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // m00, m01, m02, m10, m11, m12, m20, m21, m22 (16 bits each)
   input  logic [oewc_pkg::IN_W-1:0]         req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // inside_res[0], angle_x[16:1], angle_y[31:17], angle_z[47:32]
   output logic [oewc_pkg::OUT_W-1:0]        rsp_tdata,
   input  logic                              csr_we,
   input  logic [oewc_pkg::CFG_IDX_W-1:0]    csr_index,
   input  logic [oewc_pkg::CFG_W-1:0]        csr_wdata
);
   import oewc_pkg::*;

   logic [CFG_W-1:0]    trow0_ff, trow1_ff, trow2_ff, min_ff, max_ff;
   logic [MARGIN_W-1:0] margin_ff;
   window_type          win;
   logic                push, full, fvalid, pop;
   dmat_type            fdata, fhead;

   always_ff @(posedge clock) begin
      if (reset) begin
         trow0_ff  <= 48'd16384;
         trow1_ff  <= 48'd16384 << 16;
         trow2_ff  <= 48'd16384 << 32;
         min_ff    <= '0;
         max_ff    <= '0;
         margin_ff <= '0;
      end else if (csr_we) begin
         case (cfg_reg_type'(csr_index))
            REG_TARGET_ROW0:  trow0_ff  <= csr_wdata;
            REG_TARGET_ROW1:  trow1_ff  <= csr_wdata;
            REG_TARGET_ROW2:  trow2_ff  <= csr_wdata;
            REG_MIN_ANGLES:   min_ff    <= csr_wdata;
            REG_MAX_ANGLES:   max_ff    <= csr_wdata;
            REG_ANGLE_MARGIN: margin_ff <= csr_wdata[MARGIN_W-1:0];
            default: ;
         endcase
      end
   end

   assign win.min_angles = min_ff;
   assign win.max_angles = max_ff;
   assign win.margin     = margin_ff;

   oewc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .target_row0 (trow0_ff),
      .target_row1 (trow1_ff),
      .target_row2 (trow2_ff),
      .push_o      (push),
      .data_o      (fdata),
      .full_i      (full)
   );

   oewc_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push_i  (push),
      .data_i  (fdata),
      .full_o  (full),
      .pop_i   (pop),
      .valid_o (fvalid),
      .data_o  (fhead)
   );

   oewc_back #(.STEPS(CORDIC_STEPS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .valid_i    (fvalid),
      .data_i     (fhead),
      .pop_o      (pop),
      .win_i      (win),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> rtl/oewc_checker.sv
// ----------------------------------------------------------------------------
// oewc_checker
// Port-level checks for the orientation Euler window check unit.
// ----------------------------------------------------------------------------
module oewc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tvalid,
   input logic                        req_tready,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [oewc_pkg::OUT_W-1:0]  rsp_tdata
);
   import oewc_pkg::*;

   logic [7:0] cnt_ff;

   // requests in flight
   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else cnt_ff <= cnt_ff + 8'(req_tvalid && req_tready) - 8'(rsp_tvalid && rsp_tready);
   end

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> cnt_ff != 8'd0)
      else $error("result without a request");

   a_y_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[31:17]) <= 15'sd12868)
                  && ($signed(rsp_tdata[31:17]) >= -15'sd12868))
      else $error("y angle out of range");

endmodule

bind orientation_euler_window_check_unit oewc_checker u_oewc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
